[sv/rud_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package rud_pkg;

    localparam int IN_W        = 15;
    localparam int OUT_W       = 16;
    localparam int COORD_W     = 18;
    localparam int MAX_PIECES  = 3;
    localparam int QUEUE_DEPTH = 2;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic [1:0]                piece_cnt_t;

    typedef enum logic [3:0] {
        PIECE_A,
        PIECE_B,
        PIECE_LEFT,
        PIECE_TOP,
        PIECE_RIGHT,
        PIECE_BOTTOM,
        PIECE_REM_LEFT,
        PIECE_REM_TOP,
        PIECE_REM_RIGHT,
        PIECE_REM_BOTTOM
    } piece_kind_t;

    // both rectangles with their inclusive ends
    typedef struct packed {
        coord_t ax;
        coord_t ay;
        coord_t aw;
        coord_t ah;
        coord_t bx;
        coord_t by;
        coord_t bw;
        coord_t bh;
        coord_t ax2;
        coord_t ay2;
        coord_t bx2;
        coord_t by2;
    } rud_rects_t;

    // classified item: geometry plus the list of pieces to emit
    typedef struct packed {
        rud_rects_t                     r;
        coord_t                         ry1;
        coord_t                         rh;
        piece_kind_t [MAX_PIECES-1:0]   kinds;
        piece_cnt_t                     npieces;
    } rud_item_t;

endpackage

`default_nettype wire

[sv/rect_union_decompose_core.sv]
`timescale 1ns / 1ps
`default_nettype none

// channel  handshake             payload
// -------  --------------------  ------------------------------------------------
// in       in_valid / in_ready   a_x a_y a_width a_height b_x b_y b_width b_height
// out      out_valid / out_ready out_x out_y out_width out_height last_piece
//
// each input beat yields one to three output beats, one per cycle from the
// output stage while out_ready is high
// from input beat to first output beat an item passes the ends register, the queue and the output registers
// the front keeps taking beats while the queue has room, even when out is stalled
// rst_n clears all valid flags, queue pointers and the piece index

module rect_union_decompose_core #(
    parameter int QUEUE_DEPTH = rud_pkg::QUEUE_DEPTH
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic signed [rud_pkg::IN_W-1:0]   a_x,
    input  wire logic signed [rud_pkg::IN_W-1:0]   a_y,
    input  wire logic        [rud_pkg::IN_W-1:0]   a_width,
    input  wire logic        [rud_pkg::IN_W-1:0]   a_height,
    input  wire logic signed [rud_pkg::IN_W-1:0]   b_x,
    input  wire logic signed [rud_pkg::IN_W-1:0]   b_y,
    input  wire logic        [rud_pkg::IN_W-1:0]   b_width,
    input  wire logic        [rud_pkg::IN_W-1:0]   b_height,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic signed [rud_pkg::OUT_W-1:0]       out_x,
    output logic signed [rud_pkg::OUT_W-1:0]       out_y,
    output logic        [rud_pkg::OUT_W-1:0]       out_width,
    output logic        [rud_pkg::OUT_W-1:0]       out_height,
    output logic                                   last_piece
);

    logic               f_valid;
    logic               f_ready;
    rud_pkg::rud_item_t f_item;
    logic               q_valid;
    logic               q_ready;
    rud_pkg::rud_item_t q_item;

    rud_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .a_x        (a_x),
        .a_y        (a_y),
        .a_width    (a_width),
        .a_height   (a_height),
        .b_x        (b_x),
        .b_y        (b_y),
        .b_width    (b_width),
        .b_height   (b_height),
        .item_valid (f_valid),
        .item_ready (f_ready),
        .item       (f_item)
    );

    rud_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_data  (f_item),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_data   (q_item)
    );

    rud_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (q_valid),
        .item_ready (q_ready),
        .item       (q_item),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_x      (out_x),
        .out_y      (out_y),
        .out_width  (out_width),
        .out_height (out_height),
        .last_piece (last_piece)
    );

endmodule

`default_nettype wire

[sv/rud_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module rud_front (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic signed [rud_pkg::IN_W-1:0]   a_x,
    input  wire logic signed [rud_pkg::IN_W-1:0]   a_y,
    input  wire logic        [rud_pkg::IN_W-1:0]   a_width,
    input  wire logic        [rud_pkg::IN_W-1:0]   a_height,
    input  wire logic signed [rud_pkg::IN_W-1:0]   b_x,
    input  wire logic signed [rud_pkg::IN_W-1:0]   b_y,
    input  wire logic        [rud_pkg::IN_W-1:0]   b_width,
    input  wire logic        [rud_pkg::IN_W-1:0]   b_height,
    output logic                                   item_valid,
    input  wire logic                              item_ready,
    output rud_pkg::rud_item_t                     item
);

    localparam int PAD_W = rud_pkg::COORD_W - rud_pkg::IN_W;

    logic                s1_valid_reg;
    logic                s1_valid_next;
    rud_pkg::rud_rects_t s1_reg;
    rud_pkg::rud_rects_t s1_next;
    logic                in_fire;

    logic                disjoint;
    logic                sl;
    logic                st;
    logic                sr;
    logic                sb;
    logic [2:0]          side_cnt;
    rud_pkg::piece_kind_t first_strip;
    rud_pkg::piece_kind_t last_strip;
    rud_pkg::piece_kind_t rem_kind;
    rud_pkg::coord_t     ry2;

    assign in_ready = !s1_valid_reg || item_ready;
    assign in_fire  = in_valid && in_ready;

    // stage one: sign/zero extend and form inclusive ends
    always_comb
    begin
        s1_next.ax  = rud_pkg::coord_t'(a_x);
        s1_next.ay  = rud_pkg::coord_t'(a_y);
        s1_next.aw  = $signed({{PAD_W{1'b0}}, a_width});
        s1_next.ah  = $signed({{PAD_W{1'b0}}, a_height});
        s1_next.bx  = rud_pkg::coord_t'(b_x);
        s1_next.by  = rud_pkg::coord_t'(b_y);
        s1_next.bw  = $signed({{PAD_W{1'b0}}, b_width});
        s1_next.bh  = $signed({{PAD_W{1'b0}}, b_height});
        s1_next.ax2 = s1_next.ax + s1_next.aw - rud_pkg::coord_t'(1);
        s1_next.ay2 = s1_next.ay + s1_next.ah - rud_pkg::coord_t'(1);
        s1_next.bx2 = s1_next.bx + s1_next.bw - rud_pkg::coord_t'(1);
        s1_next.by2 = s1_next.by + s1_next.bh - rud_pkg::coord_t'(1);
    end

    always_comb
    begin
        if (in_fire)
            s1_valid_next = 1'b1;
        else if (item_ready)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
            s1_reg <= s1_next;
    end

    // stage two: classify and build the piece list
    assign disjoint = (s1_reg.ax > s1_reg.bx2) || (s1_reg.ax2 < s1_reg.bx) ||
                      (s1_reg.ay > s1_reg.by2) || (s1_reg.ay2 < s1_reg.by);
    assign sl = s1_reg.bx  < s1_reg.ax;
    assign st = s1_reg.by  < s1_reg.ay;
    assign sr = s1_reg.bx2 > s1_reg.ax2;
    assign sb = s1_reg.by2 > s1_reg.ay2;
    assign side_cnt = {2'b00, sl} + {2'b00, st} + {2'b00, sr} + {2'b00, sb};
    assign ry2 = (s1_reg.ay2 < s1_reg.by2) ? s1_reg.ay2 : s1_reg.by2;

    always_comb
    begin
        priority if (sl)
            first_strip = rud_pkg::PIECE_LEFT;
        else if (st)
            first_strip = rud_pkg::PIECE_TOP;
        else if (sr)
            first_strip = rud_pkg::PIECE_RIGHT;
        else
            first_strip = rud_pkg::PIECE_BOTTOM;

        priority if (sb)
            last_strip = rud_pkg::PIECE_BOTTOM;
        else if (sr)
            last_strip = rud_pkg::PIECE_RIGHT;
        else if (st)
            last_strip = rud_pkg::PIECE_TOP;
        else
            last_strip = rud_pkg::PIECE_LEFT;

        // side of A that B leaves uncovered
        priority if (!sl)
            rem_kind = rud_pkg::PIECE_REM_LEFT;
        else if (!st)
            rem_kind = rud_pkg::PIECE_REM_TOP;
        else if (!sr)
            rem_kind = rud_pkg::PIECE_REM_RIGHT;
        else
            rem_kind = rud_pkg::PIECE_REM_BOTTOM;
    end

    always_comb
    begin
        item.r   = s1_reg;
        item.ry1 = (s1_reg.ay > s1_reg.by) ? s1_reg.ay : s1_reg.by;
        item.rh  = ry2 - item.ry1 + rud_pkg::coord_t'(1);
        item.kinds[0] = rud_pkg::PIECE_A;
        item.kinds[1] = first_strip;
        item.kinds[2] = last_strip;
        item.npieces  = 2'd1;
        if (disjoint)
        begin
            item.kinds[0] = rud_pkg::PIECE_B;
            item.kinds[1] = rud_pkg::PIECE_A;
            item.npieces  = 2'd2;
        end
        else
        begin
            unique case (side_cnt)
                3'd0:
                    item.npieces = 2'd1;
                3'd1:
                    item.npieces = 2'd2;
                3'd2:
                    item.npieces = 2'd3;
                3'd3:
                begin
                    item.kinds[0] = rud_pkg::PIECE_B;
                    item.kinds[1] = rem_kind;
                    item.npieces  = 2'd2;
                end
                default:
                begin
                    item.kinds[0] = rud_pkg::PIECE_B;
                    item.npieces  = 2'd1;
                end
            endcase
        end
    end

    assign item_valid = s1_valid_reg;

    a_npieces_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> (item.npieces != 2'd0))
        else $error("classified item with no pieces");

endmodule

`default_nettype wire

[sv/rud_queue.sv]
`timescale 1ns / 1ps
`default_nettype none

module rud_queue #(
    parameter int DEPTH = rud_pkg::QUEUE_DEPTH
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push_valid,
    output logic                    push_ready,
    input  wire rud_pkg::rud_item_t push_data,
    output logic                    pop_valid,
    input  wire logic               pop_ready,
    output rud_pkg::rud_item_t      pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    rud_pkg::rud_item_t mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               push;
    logic               pop;

    assign push_ready = (count_reg != FULL_CNT);
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("queue count beyond depth");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (rd_ptr_reg == wr_ptr_reg))
        else $error("empty queue with pointers apart");

endmodule

`default_nettype wire

[sv/rud_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module rud_back (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              item_valid,
    output logic                                   item_ready,
    input  wire rud_pkg::rud_item_t                item,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic signed [rud_pkg::OUT_W-1:0]       out_x,
    output logic signed [rud_pkg::OUT_W-1:0]       out_y,
    output logic        [rud_pkg::OUT_W-1:0]       out_width,
    output logic        [rud_pkg::OUT_W-1:0]       out_height,
    output logic                                   last_piece
);

    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic [1:0]                 idx_reg;
    logic [1:0]                 idx_next;
    logic                       load;
    logic                       is_last;
    rud_pkg::piece_kind_t       kind;
    rud_pkg::coord_t            px;
    rud_pkg::coord_t            py;
    rud_pkg::coord_t            pw;
    rud_pkg::coord_t            ph;
    logic signed [rud_pkg::OUT_W-1:0] x_reg;
    logic signed [rud_pkg::OUT_W-1:0] y_reg;
    logic        [rud_pkg::OUT_W-1:0] w_reg;
    logic        [rud_pkg::OUT_W-1:0] h_reg;
    logic                       last_reg;

    assign load       = item_valid && (!out_valid_reg || out_ready);
    assign is_last    = (idx_reg == (item.npieces - 2'd1));
    assign item_ready = load && is_last;
    assign kind       = item.kinds[idx_reg];

    // at most one add or subtract per field for the selected piece
    always_comb
    begin
        px = item.r.ax;
        py = item.r.ay;
        pw = item.r.aw;
        ph = item.r.ah;
        unique case (kind)
            rud_pkg::PIECE_A:
            begin
                px = item.r.ax;
                py = item.r.ay;
                pw = item.r.aw;
                ph = item.r.ah;
            end
            rud_pkg::PIECE_B:
            begin
                px = item.r.bx;
                py = item.r.by;
                pw = item.r.bw;
                ph = item.r.bh;
            end
            rud_pkg::PIECE_LEFT:
            begin
                px = item.r.bx;
                py = item.ry1;
                pw = item.r.ax - item.r.bx;
                ph = item.rh;
            end
            rud_pkg::PIECE_TOP:
            begin
                px = item.r.bx;
                py = item.r.by;
                pw = item.r.bw;
                ph = item.r.ay - item.r.by;
            end
            rud_pkg::PIECE_RIGHT:
            begin
                px = item.r.ax2 + rud_pkg::coord_t'(1);
                py = item.ry1;
                pw = item.r.bx2 - item.r.ax2;
                ph = item.rh;
            end
            rud_pkg::PIECE_BOTTOM:
            begin
                px = item.r.bx;
                py = item.r.ay2 + rud_pkg::coord_t'(1);
                pw = item.r.bw;
                ph = item.r.by2 - item.r.ay2;
            end
            rud_pkg::PIECE_REM_LEFT:
            begin
                px = item.r.ax;
                py = item.r.ay;
                pw = item.r.bx - item.r.ax;
                ph = item.r.ah;
            end
            rud_pkg::PIECE_REM_TOP:
            begin
                px = item.r.ax;
                py = item.r.ay;
                pw = item.r.aw;
                ph = item.r.by - item.r.ay;
            end
            rud_pkg::PIECE_REM_RIGHT:
            begin
                px = item.r.bx2 + rud_pkg::coord_t'(1);
                py = item.r.ay;
                pw = item.r.ax2 - item.r.bx2;
                ph = item.r.ah;
            end
            rud_pkg::PIECE_REM_BOTTOM:
            begin
                px = item.r.ax;
                py = item.r.by2 + rud_pkg::coord_t'(1);
                pw = item.r.aw;
                ph = item.r.ay2 - item.r.by2;
            end
            default:
            begin
                px = item.r.ax;
                py = item.r.ay;
                pw = item.r.aw;
                ph = item.r.ah;
            end
        endcase
    end

    always_comb
    begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        if (load)
        begin
            idx_next       = is_last ? 2'd0 : idx_reg + 2'd1;
            out_valid_next = 1'b1;
        end
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            x_reg    <= px[rud_pkg::OUT_W-1:0];
            y_reg    <= py[rud_pkg::OUT_W-1:0];
            w_reg    <= pw[rud_pkg::OUT_W-1:0];
            h_reg    <= ph[rud_pkg::OUT_W-1:0];
            last_reg <= is_last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_x      = x_reg;
    assign out_y      = y_reg;
    assign out_width  = w_reg;
    assign out_height = h_reg;
    assign last_piece = last_reg;

    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid |-> (idx_reg < item.npieces))
        else $error("piece index past the item's piece count");

    a_idx_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !item_valid |-> (idx_reg == 2'd0))
        else $error("piece index left mid-item with no item at head");

endmodule

`default_nettype wire

[test/rect_union_decompose_core_test.sv]
`timescale 1ns / 1ps

module rect_union_decompose_core_test;

    localparam int SEND_CALM_FROM = 700;
    localparam int SEND_CALM_TO   = 1100;
    localparam int RECV_HOLD_FROM = 300;
    localparam int RECV_HOLD_TO   = 500;
    localparam int RECV_CALM_FROM = 700;
    localparam int RECV_CALM_TO   = 1100;
    localparam int N_RANDOM       = 406;

    typedef struct {
        logic signed [rud_pkg::IN_W-1:0] a_x;
        logic signed [rud_pkg::IN_W-1:0] a_y;
        logic        [rud_pkg::IN_W-1:0] a_width;
        logic        [rud_pkg::IN_W-1:0] a_height;
        logic signed [rud_pkg::IN_W-1:0] b_x;
        logic signed [rud_pkg::IN_W-1:0] b_y;
        logic        [rud_pkg::IN_W-1:0] b_width;
        logic        [rud_pkg::IN_W-1:0] b_height;
        bit                              settle;   // hold back until everything owed has come out
    } rect_pair_t;

    typedef struct {
        logic signed [rud_pkg::OUT_W-1:0] x;
        logic signed [rud_pkg::OUT_W-1:0] y;
        logic        [rud_pkg::OUT_W-1:0] w;
        logic        [rud_pkg::OUT_W-1:0] h;
        logic                             last;
    } piece_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic signed [rud_pkg::IN_W-1:0] a_x = '0;
    logic signed [rud_pkg::IN_W-1:0] a_y = '0;
    logic        [rud_pkg::IN_W-1:0] a_width = '0;
    logic        [rud_pkg::IN_W-1:0] a_height = '0;
    logic signed [rud_pkg::IN_W-1:0] b_x = '0;
    logic signed [rud_pkg::IN_W-1:0] b_y = '0;
    logic        [rud_pkg::IN_W-1:0] b_width = '0;
    logic        [rud_pkg::IN_W-1:0] b_height = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [rud_pkg::OUT_W-1:0] out_x;
    logic signed [rud_pkg::OUT_W-1:0] out_y;
    logic        [rud_pkg::OUT_W-1:0] out_width;
    logic        [rud_pkg::OUT_W-1:0] out_height;
    logic last_piece;

    rect_pair_t rect_pairs_q[$];
    piece_t     pending_pieces[$];
    rect_pair_t offered;

    int n_pieces_due = 0;
    int n_pieces_seen = 0;
    int n_accepted = 0;
    int n_errors = 0;
    int tx_cycle = 0;
    int rx_cycle = 0;
    int disjoint_hits = 0;
    int sides_hits[0:4] = '{0, 0, 0, 0, 0};

    rect_union_decompose_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .a_x        (a_x),
        .a_y        (a_y),
        .a_width    (a_width),
        .a_height   (a_height),
        .b_x        (b_x),
        .b_y        (b_y),
        .b_width    (b_width),
        .b_height   (b_height),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_x      (out_x),
        .out_y      (out_y),
        .out_width  (out_width),
        .out_height (out_height),
        .last_piece (last_piece)
    );

    always #10 clk = ~clk;

    function automatic void add_piece(longint x, longint y, longint w, longint h);
        piece_t p;
        p.x = x[rud_pkg::OUT_W-1:0];
        p.y = y[rud_pkg::OUT_W-1:0];
        p.w = w[rud_pkg::OUT_W-1:0];
        p.h = h[rud_pkg::OUT_W-1:0];
        p.last = 1'b0;
        pending_pieces.insert(pending_pieces.size(), p);
    endfunction

    // expected rectangles for one pair, appended to pending_pieces; returns how many
    function automatic int predict_union(rect_pair_t p);
        longint ax, ay, aw, ah, bx, by, bw, bh;
        longint ax2, ay2, bx2, by2, ry1, ry2;
        bit sl, st, sr, sb;
        int sides;
        int base;
        base = pending_pieces.size();
        ax = longint'(p.a_x);
        ay = longint'(p.a_y);
        aw = longint'(p.a_width);
        ah = longint'(p.a_height);
        bx = longint'(p.b_x);
        by = longint'(p.b_y);
        bw = longint'(p.b_width);
        bh = longint'(p.b_height);
        ax2 = ax + aw - 1;
        ay2 = ay + ah - 1;
        bx2 = bx + bw - 1;
        by2 = by + bh - 1;
        if (ax > bx2 || ax2 < bx || ay > by2 || ay2 < by)
        begin
            disjoint_hits++;
            add_piece(bx, by, bw, bh);
            add_piece(ax, ay, aw, ah);
        end
        else
        begin
            sl = bx < ax;
            st = by < ay;
            sr = bx2 > ax2;
            sb = by2 > ay2;
            sides = int'(sl) + int'(st) + int'(sr) + int'(sb);
            sides_hits[sides]++;
            ry1 = (ay > by) ? ay : by;
            ry2 = (ay2 < by2) ? ay2 : by2;
            if (sides == 0)
            begin
                add_piece(ax, ay, aw, ah);
            end
            else if (sides <= 2)
            begin
                add_piece(ax, ay, aw, ah);
                if (sl)
                    add_piece(bx, ry1, ax - bx, ry2 - ry1 + 1);
                if (st)
                    add_piece(bx, by, bw, ay - by);
                if (sr)
                    add_piece(ax2 + 1, ry1, bx2 - ax2, ry2 - ry1 + 1);
                if (sb)
                    add_piece(bx, ay2 + 1, bw, by2 - ay2);
            end
            else if (sides == 3)
            begin
                add_piece(bx, by, bw, bh);
                // the part of A on the one side B does not cover, possibly empty
                if (!sl)
                    add_piece(ax, ay, bx - ax, ah);
                else if (!st)
                    add_piece(ax, ay, aw, by - ay);
                else if (!sr)
                    add_piece(bx2 + 1, ay, ax2 - bx2, ah);
                else
                    add_piece(ax, by2 + 1, aw, ay2 - by2);
            end
            else
            begin
                add_piece(bx, by, bw, bh);
            end
        end
        pending_pieces[pending_pieces.size() - 1].last = 1'b1;
        return pending_pieces.size() - base;
    endfunction

    function automatic void queue_pair(int ax, int ay, int aw, int ah,
                                       int bx, int by, int bw, int bh, bit settle);
        rect_pair_t p;
        p.a_x = ax[rud_pkg::IN_W-1:0];
        p.a_y = ay[rud_pkg::IN_W-1:0];
        p.a_width = aw[rud_pkg::IN_W-1:0];
        p.a_height = ah[rud_pkg::IN_W-1:0];
        p.b_x = bx[rud_pkg::IN_W-1:0];
        p.b_y = by[rud_pkg::IN_W-1:0];
        p.b_width = bw[rud_pkg::IN_W-1:0];
        p.b_height = bh[rud_pkg::IN_W-1:0];
        p.settle = settle;
        rect_pairs_q.insert(rect_pairs_q.size(), p);
    endfunction

    function automatic void queue_random_pair(bit settle);
        int pick, span, ax, ay, aw, ah, bw, bh, offx, offy;
        pick = $urandom_range(0, 99);
        if (pick < 15)
        begin
            // anything the fields can hold, zero and oversized sizes included
            queue_pair($urandom, $urandom, $urandom, $urandom,
                       $urandom, $urandom, $urandom, $urandom, settle);
        end
        else
        begin
            if (pick < 70)
                span = 12;
            else if (pick < 90)
                span = 2000;
            else
                span = 16384;
            aw = $urandom_range(1, span);
            ah = $urandom_range(1, span);
            bw = $urandom_range(1, span);
            bh = $urandom_range(1, span);
            ax = int'($urandom_range(0, 32767)) - 16384;
            ay = int'($urandom_range(0, 32767)) - 16384;
            // B placed around A so that every overlap shape comes up, edges often shared
            offx = int'($urandom_range(0, aw + bw + 2)) - (bw + 1);
            offy = int'($urandom_range(0, ah + bh + 2)) - (bh + 1);
            queue_pair(ax, ay, aw, ah, ax + offx, ay + offy, bw, bh, settle);
        end
    endfunction

    // sender
    always @(posedge clk or negedge rst_n)
    begin : driver
        int produced;
        bit idle;
        bit drained;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            tx_cycle <= 0;
        end
        else
        begin
            produced = 0;
            tx_cycle <= tx_cycle + 1;
            if (in_valid && in_ready)
            begin
                produced = predict_union(offered);
                n_pieces_due <= n_pieces_due + produced;
                n_accepted++;
            end
            if (!in_valid || in_ready)
            begin
                if (tx_cycle >= SEND_CALM_FROM && tx_cycle < SEND_CALM_TO)
                    idle = 1'b0;
                else
                    idle = ($urandom_range(0, 99) < 30);
                drained = (n_pieces_due + produced == n_pieces_seen);
                if (rect_pairs_q.size() != 0 && !idle && (drained || !rect_pairs_q[0].settle))
                begin
                    offered = rect_pairs_q.pop_front();
                    a_x <= offered.a_x;
                    a_y <= offered.a_y;
                    a_width <= offered.a_width;
                    a_height <= offered.a_height;
                    b_x <= offered.b_x;
                    b_y <= offered.b_y;
                    b_width <= offered.b_width;
                    b_height <= offered.b_height;
                    in_valid <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: random stalls, one long hold-off so the front fills and backs up
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            rx_cycle <= 0;
        end
        else
        begin
            rx_cycle <= rx_cycle + 1;
            if (rx_cycle >= RECV_HOLD_FROM && rx_cycle < RECV_HOLD_TO)
                out_ready <= 1'b0;
            else if (rx_cycle >= RECV_CALM_FROM && rx_cycle < RECV_CALM_TO)
                out_ready <= 1'b1;
            else
                out_ready <= ($urandom_range(0, 99) >= 30);
        end
    end

    task automatic check_field(string name, logic [rud_pkg::OUT_W-1:0] want,
                               logic [rud_pkg::OUT_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
            n_errors++;
        end
    endtask

    // checker of output beats
    always @(posedge clk)
    begin : monitor
        piece_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_pieces.size() == 0)
            begin
                $display("%0t: unexpected beat, expected none, got x=%0d y=%0d w=%0d h=%0d last=%b",
                         $time, out_x, out_y, out_width, out_height, last_piece);
                n_errors++;
            end
            else
            begin
                want = pending_pieces.pop_front();
                check_field("out_x", want.x, out_x);
                check_field("out_y", want.y, out_y);
                check_field("out_width", want.w, out_width);
                check_field("out_height", want.h, out_height);
                check_field("last_piece", {15'd0, want.last}, {15'd0, last_piece});
                n_pieces_seen <= n_pieces_seen + 1;
            end
        end
    end

    initial
    begin
        #(5_000_000);
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        // disjoint, including edge-touching rectangles and zero sizes
        queue_pair(0, 0, 10, 10, 20, 20, 5, 5, 1'b0);
        queue_pair(0, 0, 10, 10, 10, 0, 4, 10, 1'b0);
        queue_pair(0, 0, 0, 0, 0, 0, 0, 0, 1'b0);
        // B inside A, and identical
        queue_pair(0, 0, 10, 10, 2, 2, 3, 3, 1'b0);
        queue_pair(5, 5, 8, 8, 5, 5, 8, 8, 1'b0);
        queue_pair(0, 0, 10, 10, 3, 3, 0, 5, 1'b0);
        // one side out
        queue_pair(0, 0, 10, 10, -3, 2, 5, 4, 1'b0);
        queue_pair(0, 0, 10, 10, 2, -4, 3, 6, 1'b0);
        queue_pair(0, 0, 10, 10, 7, 1, 6, 3, 1'b0);
        queue_pair(0, 0, 10, 10, 1, 8, 4, 5, 1'b0);
        // two sides out
        queue_pair(0, 0, 10, 10, -2, -2, 5, 5, 1'b0);
        queue_pair(0, 0, 10, 10, 8, 8, 5, 5, 1'b0);
        queue_pair(0, 0, 10, 10, -2, 3, 14, 2, 1'b0);
        queue_pair(0, 0, 10, 10, 3, -2, 2, 14, 1'b0);
        // three sides out, each side left over, then an empty leftover strip
        queue_pair(0, 0, 10, 10, 4, -1, 8, 12, 1'b0);
        queue_pair(0, 0, 10, 10, -1, 3, 12, 9, 1'b0);
        queue_pair(0, 0, 10, 10, -1, -1, 6, 12, 1'b0);
        queue_pair(0, 0, 10, 10, -1, -1, 12, 5, 1'b0);
        queue_pair(0, 0, 10, 10, 0, -1, 11, 12, 1'b0);
        // four sides out
        queue_pair(0, 0, 10, 10, -1, -1, 12, 12, 1'b0);
        queue_pair(100, 100, 1, 1, -16384, -16384, 32767, 32767, 1'b0);
        // coordinate and size extremes, wrapping outputs
        queue_pair(-16384, -16384, 1, 1, 16383, 16383, 1, 1, 1'b0);
        queue_pair(-16384, -16384, 16384, 16384, -1, -1, 16384, 16384, 1'b0);
        queue_pair(16383, 16383, 32767, 32767, -16384, -16384, 32767, 32767, 1'b0);
        for (int i = 0; i < N_RANDOM; i++)
            queue_random_pair(i == 0 || i == N_RANDOM / 2);

        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (rect_pairs_q.size() != 0 || in_valid)
            @(negedge clk);
        while (pending_pieces.size() != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);

        if (pending_pieces.size() != 0)
        begin
            $display("%0t: %0d expected rectangles never came out", $time, pending_pieces.size());
            n_errors++;
        end
        $display("summary: %0d pairs in, %0d rectangles checked, %0d mismatches",
                 n_accepted, n_pieces_seen, n_errors);
        $display("summary: disjoint %0d, sides out 0/1/2/3/4: %0d/%0d/%0d/%0d/%0d",
                 disjoint_hits, sides_hits[0], sides_hits[1], sides_hits[2],
                 sides_hits[3], sides_hits[4]);
        if (n_errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
